// File: rtl/core/eight_bit_register_core_assert.svh
// Assertion macros used by the core's top-level RTL file.
// Each macro expects clk and rst_n in scope.
`ifndef EIGHT_BIT_REGISTER_CORE_ASSERT_SVH
`define EIGHT_BIT_REGISTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define EBRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("core assertion failed");

// Implication checked in the following cycle.
`define EBRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("core assertion failed");

`endif

// File: rtl/core/ebrc_pkg.sv
package ebrc_pkg;

  localparam int REG_W    = 8;
  localparam int NUM_REGS = 8;
  localparam int REG_AW   = 3;
  localparam int INSTR_W  = 15;

  // Instruction word fields.
  localparam int OP_MSB  = 14;
  localparam int OP_LSB  = 11;
  localparam int DST_MSB = 10;
  localparam int DST_LSB = 8;
  localparam int SRA_MSB = 5;
  localparam int SRA_LSB = 3;
  localparam int SRB_MSB = 2;
  localparam int SRB_LSB = 0;
  localparam int IMM_MSB = 7;
  localparam int IMM_LSB = 0;

  typedef enum logic [3:0] {
    OP_MOV   = 4'd0,
    OP_MOVI  = 4'd1,
    OP_STORE = 4'd2,
    OP_LOAD  = 4'd3,
    OP_ADD   = 4'd4,
    OP_SUB   = 4'd5,
    OP_AND   = 4'd6,
    OP_OR    = 4'd7,
    OP_XOR   = 4'd8,
    OP_JMP   = 4'd9,
    OP_JZ    = 4'd10,
    OP_JNZ   = 4'd11,
    OP_ABORT = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    RUN_WAIT = 2'd0,
    RUN_GO   = 2'd1,
    RUN_HALT = 2'd2
  } run_t;

  typedef struct packed {
    logic               start_req;
    logic [INSTR_W-1:0] instr;
    logic [REG_W-1:0]   load_data;
  } ebrc_in_t;

  typedef struct packed {
    logic             executed;
    logic [REG_W-1:0] next_ip;
    logic             mem_read;
    logic             mem_write;
    logic [REG_W-1:0] mem_addr;
    logic [REG_W-1:0] mem_data;
    logic [REG_W-1:0] dest_value;
    logic             zero;
    logic             abort;
    logic             illegal;
    logic             halted;
  } ebrc_out_t;

  // Architectural scalar state.
  typedef struct packed {
    run_t             run;
    logic [REG_W-1:0] ip;
    logic             zero;
    logic [REG_W-1:0] addr;
    logic [REG_W-1:0] data;
    logic             abort;
    logic             illegal;
  } arch_t;

  // Register file write-back.
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [REG_W-1:0]  data;
  } wb_t;

  function automatic logic op_is_alu(input logic [3:0] op);
    return (op >= OP_ADD) && (op <= OP_XOR);
  endfunction

endpackage

// File: rtl/core/ebrc_regfile.sv
module ebrc_regfile (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [ebrc_pkg::REG_AW-1:0]   rd_addr0,
  input  logic [ebrc_pkg::REG_AW-1:0]   rd_addr1,
  input  ebrc_pkg::wb_t                 wr,
  output logic [ebrc_pkg::REG_W-1:0]    rd_data0,
  output logic [ebrc_pkg::REG_W-1:0]    rd_data1
);
  import ebrc_pkg::*;

  logic [REG_W-1:0]    mem [NUM_REGS];
  logic [REG_W-1:0]    rdata0_r, rdata1_r;
  logic [REG_AW-1:0]   raddr0_r, raddr1_r;
  logic [NUM_REGS-1:0] vld_r;
  wb_t                 fwd_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rdata0_r <= mem[rd_addr0];
      rdata1_r <= mem[rd_addr1];
      raddr0_r <= rd_addr0;
      raddr1_r <= rd_addr1;
    end
  end

  // Valid bits stand in for clearing the array at reset. The last write is
  // kept so that a read issued on the same edge as that write still sees it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      fwd_r.en <= 1'b0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
      fwd_r          <= wr;
    end
  end

  always_comb begin
    if (fwd_r.en && (fwd_r.addr == raddr0_r)) begin
      rd_data0 = fwd_r.data;
    end else begin
      rd_data0 = vld_r[raddr0_r] ? rdata0_r : '0;
    end
    if (fwd_r.en && (fwd_r.addr == raddr1_r)) begin
      rd_data1 = fwd_r.data;
    end else begin
      rd_data1 = vld_r[raddr1_r] ? rdata1_r : '0;
    end
  end

endmodule

// File: rtl/core/ebrc_exec.sv
module ebrc_exec (
  input  ebrc_pkg::ebrc_in_t          item,
  input  ebrc_pkg::arch_t             arch,
  input  logic [ebrc_pkg::REG_W-1:0]  opa,
  input  logic [ebrc_pkg::REG_W-1:0]  opb,
  output ebrc_pkg::arch_t             arch_nxt,
  output ebrc_pkg::wb_t               wb,
  output ebrc_pkg::ebrc_out_t         res
);
  import ebrc_pkg::*;

  logic [3:0]        op;
  logic [REG_W-1:0]  imm;
  logic [REG_W-1:0]  ipn;
  logic [REG_W-1:0]  alu;
  logic              executed;
  logic              show;
  logic              rd;
  logic              wr;

  assign op  = item.instr[OP_MSB:OP_LSB];
  assign imm = item.instr[IMM_MSB:IMM_LSB];
  assign ipn = REG_W'(arch.ip + 8'd1);

  // Operand port 0 carries R[a] for ALU ops and R[d] otherwise; port 1 is R[b].
  always_comb begin
    unique case (op)
      OP_ADD:  alu = REG_W'(opa + opb);
      OP_SUB:  alu = REG_W'(opa - opb);
      OP_AND:  alu = opa & opb;
      OP_OR:   alu = opa | opb;
      default: alu = opa ^ opb;
    endcase
  end

  always_comb begin
    arch_nxt = arch;
    wb.en    = 1'b0;
    wb.addr  = item.instr[DST_MSB:DST_LSB];
    wb.data  = alu;
    executed = 1'b0;
    show     = 1'b0;
    rd       = 1'b0;
    wr       = 1'b0;
    unique case (arch.run)
      RUN_WAIT: begin
        if (item.start_req) begin
          arch_nxt.run = RUN_GO;
        end
      end
      RUN_GO: begin
        executed = 1'b1;
        show     = 1'b1;
        arch_nxt.ip = ipn;
        unique case (op)
          OP_MOV: begin
            wb.en   = 1'b1;
            wb.data = opb;
          end
          OP_MOVI: begin
            wb.en   = 1'b1;
            wb.data = imm;
          end
          OP_STORE: begin
            arch_nxt.addr = imm;
            arch_nxt.data = opa;
            wr = 1'b1;
          end
          OP_LOAD: begin
            arch_nxt.addr = imm;
            wb.en   = 1'b1;
            wb.data = item.load_data;
            rd = 1'b1;
          end
          OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: begin
            wb.en = 1'b1;
            arch_nxt.zero = (alu == '0);
          end
          OP_JMP: arch_nxt.ip = imm;
          OP_JZ:  arch_nxt.ip = arch.zero ? imm : ipn;
          OP_JNZ: arch_nxt.ip = arch.zero ? ipn : imm;
          OP_ABORT: begin
            arch_nxt.ip    = arch.ip;
            arch_nxt.abort = 1'b1;
            arch_nxt.run   = RUN_HALT;
          end
          default: begin
            // Undefined opcode: halt in place, nothing reported as executed.
            arch_nxt.ip      = arch.ip;
            arch_nxt.illegal = 1'b1;
            arch_nxt.run     = RUN_HALT;
            executed = 1'b0;
            show     = 1'b0;
          end
        endcase
      end
      default: begin
        arch_nxt = arch;
      end
    endcase
  end

  always_comb begin
    res.executed   = executed;
    res.next_ip    = arch_nxt.ip;
    res.mem_read   = rd;
    res.mem_write  = wr;
    res.mem_addr   = arch_nxt.addr;
    res.mem_data   = arch_nxt.data;
    res.dest_value = !show ? '0 : (wb.en ? wb.data : opa);
    res.zero       = arch_nxt.zero;
    res.abort      = arch_nxt.abort;
    res.illegal    = arch_nxt.illegal;
    res.halted     = (arch_nxt.run == RUN_HALT);
  end

endmodule

// File: rtl/core/eight_bit_register_core.sv
// Channel   Direction  Payload     Handshake
// in_       input      ebrc_in_t   in_valid / in_stall
// out_      output     ebrc_out_t  out_valid / out_stall
//
// One item is accepted per clock unless in_stall is high; its result is
// registered as the item leaves the execute stage. Operands are read at
// the accept edge and written back as the item retires, with that write
// forwarded to a read issued on the same edge. Reset (rst_n low, synchronous)
// puts the core in the waiting state with all registers reading as zero.
// The input stalls only while a stalled result holds the output register.
`include "eight_bit_register_core_assert.svh"

module eight_bit_register_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ebrc_pkg::ebrc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ebrc_pkg::ebrc_out_t out_data
);
  import ebrc_pkg::*;

  logic              accept;
  logic              s1_adv;
  logic              s1_valid_r;
  ebrc_in_t          s1_item_r;
  logic              out_valid_r;
  ebrc_out_t         out_data_r;
  arch_t             arch_r;
  arch_t             arch_nxt;
  wb_t               wb;
  wb_t               wb_gated;
  ebrc_out_t         res;
  logic [3:0]        in_op;
  logic [REG_AW-1:0] rd_addr0;
  logic [REG_W-1:0]  opa;
  logic [REG_W-1:0]  opb;

  // The execute stage moves on whenever the output register is free or
  // being emptied this cycle.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  // Operand addresses come straight from the incoming instruction word.
  assign in_op    = in_data.instr[OP_MSB:OP_LSB];
  assign rd_addr0 = op_is_alu(in_op) ? in_data.instr[SRA_MSB:SRA_LSB]
                                     : in_data.instr[DST_MSB:DST_LSB];

  ebrc_regfile u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (in_data.instr[SRB_MSB:SRB_LSB]),
    .wr       (wb_gated),
    .rd_data0 (opa),
    .rd_data1 (opb)
  );

  ebrc_exec u_exec (
    .item     (s1_item_r),
    .arch     (arch_r),
    .opa      (opa),
    .opb      (opb),
    .arch_nxt (arch_nxt),
    .wb       (wb),
    .res      (res)
  );

  // Write back only when the item actually leaves the execute stage.
  always_comb begin
    wb_gated    = wb;
    wb_gated.en = wb.en && s1_adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      arch_r.run     <= RUN_WAIT;
      arch_r.ip      <= '0;
      arch_r.zero    <= 1'b0;
      arch_r.addr    <= '0;
      arch_r.data    <= '0;
      arch_r.abort   <= 1'b0;
      arch_r.illegal <= 1'b0;
    end else begin
      s1_valid_r <= accept || (s1_valid_r && !s1_adv);
      if (s1_adv) begin
        arch_r      <= arch_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Halting is final until reset.
  `EBRC_ASSERT_NEXT(a_halt_sticky, arch_r.run == RUN_HALT, arch_r.run == RUN_HALT)
  // Either halt flag implies the halted state.
  `EBRC_ASSERT_NOW(a_flag_halts, arch_r.abort || arch_r.illegal, arch_r.run == RUN_HALT)
  // Only a running core writes the register file.
  `EBRC_ASSERT_NOW(a_wb_running, wb_gated.en, arch_r.run == RUN_GO)
  // The instruction pointer moves only when an item retires.
  `EBRC_ASSERT_NEXT(a_ip_hold, !s1_adv, $stable(arch_r.ip))

endmodule
